// File: sv/rfd_pkg.sv
// Shared types and constants for the remote frame decoder.
// No dependencies; every other file but the two interfaces imports this package.
`timescale 1ns / 1ps

package rfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [10:0] CHANNEL_LIMIT_RST = 11'd2000;
    localparam logic [1:0]  SW_DOWN           = 2'd1;
    localparam logic [1:0]  SW_NONE           = 2'd0;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_IDLE = 1'b1;

    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    // Write request into the frame store.
    typedef struct packed {
        logic       wr_en;
        logic [7:0] data;
    } t_store_wr;

    typedef struct packed {
        logic [10:0]        stick_0;
        logic [10:0]        stick_1;
        logic [10:0]        stick_2;
        logic [10:0]        stick_3;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        buttons;
        logic [15:0]        key_mask;
        logic signed [15:0] wheel;
        logic               data_error;
    } t_result;

endpackage

// File: sv/rfd_in_if.sv
// Input channel of the remote frame decoder: valid/ready plus mode and byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface rfd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// File: sv/rfd_out_if.sv
// Result channel of the remote frame decoder: valid/ready plus decoded fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface rfd_out_if;
    logic               valid;
    logic               ready;
    logic [10:0]        stick_0;
    logic [10:0]        stick_1;
    logic [10:0]        stick_2;
    logic [10:0]        stick_3;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        buttons;
    logic [15:0]        key_mask;
    logic signed [15:0] wheel;
    logic               data_error;

    modport source (
        output valid, output stick_0, output stick_1, output stick_2, output stick_3,
        output switches, output mouse_x, output mouse_y, output mouse_z,
        output buttons, output key_mask, output wheel, output data_error,
        input ready
    );
    modport sink (
        input valid, input stick_0, input stick_1, input stick_2, input stick_3,
        input switches, input mouse_x, input mouse_y, input mouse_z,
        input buttons, input key_mask, input wheel, input data_error,
        output ready
    );
endinterface

// File: sv/rfd_frame_store.sv
// Frame byte store with wrapping write index, cleared at reset.
// Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_frame_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfd_pkg::t_store_wr i_wr,
    output rfd_pkg::t_frame    o_frame
);
    import rfd_pkg::*;

    t_frame           r_store;
    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] n_wr_idx;

    always_comb begin
        n_wr_idx = r_wr_idx;
        if (i_wr.wr_en) begin
            if (r_wr_idx == IDX_W'(FRAME_BYTES - 1)) begin
                n_wr_idx = '0;
            end else begin
                n_wr_idx = r_wr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store  <= '0;
            r_wr_idx <= '0;
        end else begin
            if (i_wr.wr_en) begin
                r_store[r_wr_idx] <= i_wr.data;
            end
            r_wr_idx <= n_wr_idx;
        end
    end

    assign o_frame = r_store;

endmodule

// File: sv/rfd_decode.sv
// Field extraction and range check of one stored frame.
// Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_decode (
    input  rfd_pkg::t_frame  i_frame,
    input  logic [10:0]      i_channel_limit,
    output rfd_pkg::t_result o_result
);
    import rfd_pkg::*;

    logic [10:0] ch0, ch1, ch2, ch3;
    logic [1:0]  sw1, sw2;
    logic        err;

    always_comb begin
        ch0 = {i_frame[1][2:0], i_frame[0]};
        ch1 = {i_frame[2][5:0], i_frame[1][7:3]};
        ch2 = {i_frame[4][0], i_frame[3], i_frame[2][7:6]};
        ch3 = {i_frame[5][3:0], i_frame[4][7:1]};
        sw1 = i_frame[5][7:6];
        sw2 = i_frame[5][5:4];

        err = (ch0 > i_channel_limit) || (ch1 > i_channel_limit) ||
              (ch2 > i_channel_limit) || (ch3 > i_channel_limit) ||
              (sw1 == SW_NONE) || (sw2 == SW_NONE);

        o_result.wheel      = {i_frame[17], i_frame[16]};
        o_result.data_error = err;
        if (err) begin
            // failsafe: sticks and inputs zeroed, switches down, wheel kept
            o_result.stick_0  = '0;
            o_result.stick_1  = '0;
            o_result.stick_2  = '0;
            o_result.stick_3  = '0;
            o_result.switches = {SW_DOWN, SW_DOWN};
            o_result.mouse_x  = '0;
            o_result.mouse_y  = '0;
            o_result.mouse_z  = '0;
            o_result.buttons  = '0;
            o_result.key_mask = '0;
        end else begin
            o_result.stick_0  = ch0;
            o_result.stick_1  = ch1;
            o_result.stick_2  = ch2;
            o_result.stick_3  = ch3;
            o_result.switches = {sw1, sw2};
            o_result.mouse_x  = {i_frame[7], i_frame[6]};
            o_result.mouse_y  = {i_frame[9], i_frame[8]};
            o_result.mouse_z  = {i_frame[11], i_frame[10]};
            o_result.buttons  = {i_frame[13], i_frame[12]};
            o_result.key_mask = {i_frame[15], i_frame[14]};
        end
    end

endmodule

// File: sv/rfd_out_buf.sv
// Result register with one skid entry, decoupling input ready from output ready.
// Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rfd_pkg::t_result i_result,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output rfd_pkg::t_result o_result
);
    import rfd_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    out_fire;

    assign out_fire = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_result;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("item pushed with skid entry occupied");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && i_push) |=> r_skid_valid)
        else $error("stalled result lost incoming item");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && out_fire) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to result register");

endmodule

// File: sv/remote_frame_decoder.sv
// Top level of the remote frame decoder: byte store, decode, result buffer.
// Depends on rfd_pkg, rfd_in_if, rfd_out_if, rfd_frame_store, rfd_decode, rfd_out_buf.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        mode, rx_byte
//   o_out     out  valid/ready        sticks, switches, mouse, buttons, keys, wheel, error
//   i_cfg_*   in   write enable only  channel_limit (11 bit)
//
// One item per cycle while i_in.ready is high: a byte goes into the store at the
// accepting edge; an idle event decodes the store in the same cycle into the result
// register or skid. A result is visible in the cycle after its idle event is accepted
// when the result register is free; else it waits in the skid entry until that drains.
// Reset (synchronous, active low) clears the store, write index and result valid
// flags; channel_limit returns to 2000.
// i_in.ready drops only when both the result register and the skid entry are full.
`timescale 1ns / 1ps

module remote_frame_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [10:0]   i_cfg_wr_data,
    rfd_in_if.sink        i_in,
    rfd_out_if.source     o_out
);
    import rfd_pkg::*;

    logic [10:0] r_channel_limit;
    logic        in_fire;
    logic        space;
    t_store_wr   store_wr;
    t_frame      frame;
    t_result     dec_result;
    t_result     out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_limit <= CHANNEL_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_channel_limit <= i_cfg_wr_data;
        end
    end

    assign i_in.ready     = space;
    assign in_fire        = i_in.valid && space;
    assign store_wr.wr_en = in_fire && (i_in.mode == MODE_BYTE);
    assign store_wr.data  = i_in.rx_byte;

    rfd_frame_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (store_wr),
        .o_frame (frame)
    );

    rfd_decode u_decode (
        .i_frame         (frame),
        .i_channel_limit (r_channel_limit),
        .o_result        (dec_result)
    );

    rfd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_fire && (i_in.mode == MODE_IDLE)),
        .i_result (dec_result),
        .o_space  (space),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (out_result)
    );

    assign o_out.stick_0    = out_result.stick_0;
    assign o_out.stick_1    = out_result.stick_1;
    assign o_out.stick_2    = out_result.stick_2;
    assign o_out.stick_3    = out_result.stick_3;
    assign o_out.switches   = out_result.switches;
    assign o_out.mouse_x    = out_result.mouse_x;
    assign o_out.mouse_y    = out_result.mouse_y;
    assign o_out.mouse_z    = out_result.mouse_z;
    assign o_out.buttons    = out_result.buttons;
    assign o_out.key_mask   = out_result.key_mask;
    assign o_out.wheel      = out_result.wheel;
    assign o_out.data_error = out_result.data_error;

endmodule

// File: verif/tb_top.sv
// Self-checking bench for remote_frame_decoder: queue-fed byte/idle driver, result monitor,
// and a frame decode predictor with its own store, write position and channel limit.
// Depends on rfd_pkg, rfd_in_if, rfd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import rfd_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int MAX_SHOWN       = 10;
    localparam int PHASE_ITEMS     = 140;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } t_rx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [10:0] i_cfg_wr_data;

    rfd_in_if  in_ch ();
    rfd_out_if out_ch ();

    remote_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  store_img [FRAME_BYTES];
    int          wr_pos;
    logic [10:0] limit_now;

    t_rx_item    rx_pending [$];
    t_result     decoded_q [$];
    t_rx_item    cur_item;
    int          gap_left;
    int          stall_left;
    bit          drain_hold;
    bit          no_gaps;
    int          stream_pos;
    int          mismatches;
    int          quiet_cycles;

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic predict_item(t_rx_item it);
        t_result     r;
        logic [10:0] ch [4];
        logic [1:0]  sw1, sw2;
        logic        bad;
        int          i;
        if (it.mode == MODE_BYTE) begin
            if (wr_pos >= FRAME_BYTES) wr_pos = 0;
            store_img[wr_pos] = it.data;
            wr_pos = (wr_pos == FRAME_BYTES - 1) ? 0 : wr_pos + 1;
        end else begin
            ch[0] = {store_img[1][2:0], store_img[0]};
            ch[1] = {store_img[2][5:0], store_img[1][7:3]};
            ch[2] = {store_img[4][0], store_img[3], store_img[2][7:6]};
            ch[3] = {store_img[5][3:0], store_img[4][7:1]};
            sw1   = store_img[5][7:6];
            sw2   = store_img[5][5:4];
            bad   = (sw1 == SW_NONE) || (sw2 == SW_NONE);
            for (i = 0; i < 4; i++)
                if (ch[i] > limit_now) bad = 1'b1;
            r.stick_0    = ch[0];
            r.stick_1    = ch[1];
            r.stick_2    = ch[2];
            r.stick_3    = ch[3];
            r.switches   = {sw1, sw2};
            r.mouse_x    = {store_img[7], store_img[6]};
            r.mouse_y    = {store_img[9], store_img[8]};
            r.mouse_z    = {store_img[11], store_img[10]};
            r.buttons    = {store_img[13], store_img[12]};
            r.key_mask   = {store_img[15], store_img[14]};
            r.wheel      = {store_img[17], store_img[16]};
            r.data_error = bad;
            if (bad) begin
                // defaults on a bad frame; wheel passes through untouched
                r.stick_0  = '0;
                r.stick_1  = '0;
                r.stick_2  = '0;
                r.stick_3  = '0;
                r.switches = {SW_DOWN, SW_DOWN};
                r.mouse_x  = '0;
                r.mouse_y  = '0;
                r.mouse_z  = '0;
                r.buttons  = '0;
                r.key_mask = '0;
            end
            decoded_q.push_back(r);
        end
    endtask

    function automatic void note_field(string name, logic [15:0] want, logic [15:0] seen);
        if (seen !== want) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t mismatch %s: expected %h, got %h", $realtime, name, want, seen);
        end
    endfunction

    task automatic check_decoded();
        t_result want;
        if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t result with no decode pending", $realtime);
        end else begin
            want = decoded_q.pop_front();
            note_field("stick_0", 16'(want.stick_0), 16'(out_ch.stick_0));
            note_field("stick_1", 16'(want.stick_1), 16'(out_ch.stick_1));
            note_field("stick_2", 16'(want.stick_2), 16'(out_ch.stick_2));
            note_field("stick_3", 16'(want.stick_3), 16'(out_ch.stick_3));
            note_field("switches", 16'(want.switches), 16'(out_ch.switches));
            note_field("mouse_x", want.mouse_x, out_ch.mouse_x);
            note_field("mouse_y", want.mouse_y, out_ch.mouse_y);
            note_field("mouse_z", want.mouse_z, out_ch.mouse_z);
            note_field("buttons", want.buttons, out_ch.buttons);
            note_field("key_mask", want.key_mask, out_ch.key_mask);
            note_field("wheel", want.wheel, out_ch.wheel);
            note_field("data_error", 16'(want.data_error), 16'(out_ch.data_error));
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_item(cur_item);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (drain_hold && decoded_q.size() != 0) begin
                    in_ch.valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    drain_hold = 1'b0;
                    cur_item = rx_pending.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.mode    <= cur_item.mode;
                    in_ch.rx_byte <= cur_item.data;
                    gap_left = no_gaps ? 0 : idle_len();
                    // now and then hold off until every decode has come back
                    if (cur_item.mode == MODE_IDLE && $urandom_range(0, 39) == 0)
                        drain_hold = 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_decoded();
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = no_gaps ? 0 : idle_len();
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("[remote_frame_decoder] ERROR");
            $finish;
        end
    end

    function automatic t_frame pack_frame(logic [10:0] c0, logic [10:0] c1, logic [10:0] c2,
                                          logic [10:0] c3, logic [1:0] s1, logic [1:0] s2,
                                          logic [15:0] mx, logic [15:0] my, logic [15:0] mz,
                                          logic [15:0] btn, logic [15:0] keys,
                                          logic [15:0] whl);
        t_frame fr;
        fr[0]  = c0[7:0];
        fr[1]  = {c1[4:0], c0[10:8]};
        fr[2]  = {c2[1:0], c1[10:5]};
        fr[3]  = c2[9:2];
        fr[4]  = {c3[6:0], c2[10]};
        fr[5]  = {s1, s2, c3[10:7]};
        fr[6]  = mx[7:0];
        fr[7]  = mx[15:8];
        fr[8]  = my[7:0];
        fr[9]  = my[15:8];
        fr[10] = mz[7:0];
        fr[11] = mz[15:8];
        fr[12] = btn[7:0];
        fr[13] = btn[15:8];
        fr[14] = keys[7:0];
        fr[15] = keys[15:8];
        fr[16] = whl[7:0];
        fr[17] = whl[15:8];
        return fr;
    endfunction

    function automatic logic [10:0] rand_channel(logic [10:0] lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 11'($urandom_range(0, 2047));
        if (r < 12) return lim;
        return 11'($urandom_range(0, int'(lim)));
    endfunction

    function automatic logic [1:0] rand_switch();
        if ($urandom_range(0, 99) < 4) return SW_NONE;
        return 2'($urandom_range(1, 3));
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_frame random_frame(logic [10:0] lim);
        return pack_frame(rand_channel(lim), rand_channel(lim), rand_channel(lim),
                          rand_channel(lim), rand_switch(), rand_switch(),
                          rand_word(), rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word());
    endfunction

    task automatic push_byte(logic [7:0] b);
        rx_pending.push_back('{mode: MODE_BYTE, data: b});
        stream_pos = (stream_pos + 1) % FRAME_BYTES;
    endtask

    // rx_byte is don't-care on an idle item, so it carries noise
    task automatic push_idle();
        rx_pending.push_back('{mode: MODE_IDLE, data: 8'($urandom_range(0, 255))});
    endtask

    task automatic push_frame(t_frame fr);
        int i;
        for (i = 0; i < FRAME_BYTES; i++) push_byte(fr[i]);
        push_idle();
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (rx_pending.size() != 0 || in_ch.valid || decoded_q.size() != 0);
    endtask

    task automatic write_limit(logic [10:0] v);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_now = v;
        @(negedge i_clk);
    endtask

    task automatic fill_phase(int n_items);
        int pushed;
        int kind;
        int k;
        pushed = 0;
        while (pushed < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                // pad out to a frame boundary, then a whole frame
                while (stream_pos != 0) begin
                    push_byte(8'($urandom_range(0, 255)));
                    pushed++;
                end
                push_frame(random_frame(limit_now));
                pushed += FRAME_BYTES + 1;
            end else if (kind < 90) begin
                k = $urandom_range(1, 7);
                repeat (k) push_byte(8'($urandom_range(0, 255)));
                pushed += k;
            end else if (kind < 95) begin
                push_idle();
                pushed++;
            end else begin
                k = $urandom_range(1, FRAME_BYTES - 1);
                repeat (k) push_byte(8'($urandom_range(0, 255)));
                push_idle();
                pushed += k + 1;
            end
        end
    endtask

    initial begin
        logic [10:0] phase_limit [7];
        bit          phase_calm  [7];
        int          p;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_BYTE;
        in_ch.rx_byte = 8'h00;
        out_ch.ready  = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_rst_n       = 1'b0;
        foreach (store_img[i]) store_img[i] = 8'h00;
        wr_pos       = 0;
        limit_now    = CHANNEL_LIMIT_RST;
        gap_left     = 0;
        stall_left   = 0;
        drain_hold   = 1'b0;
        no_gaps      = 1'b0;
        stream_pos   = 0;
        mismatches   = 0;
        quiet_cycles = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // store still clear: switches read zero, so error defaults
        push_idle();
        // clean frame with a stick right at the limit and extreme words
        push_frame(pack_frame(11'd2000, 11'd0, 11'd1024, 11'd1999, 2'd3, 2'd1,
                              16'h8000, 16'h7FFF, 16'hFFFF, 16'hFF00, 16'hFFFF,
                              16'h8000));
        // partial frame: two bytes push stick 0 one past the limit
        push_byte(8'hD1);
        push_byte(8'h07);
        push_idle();
        // idle again: write position is not rewound, same decode
        push_idle();

        phase_limit = '{11'd2047, 11'd0, 11'd2000, 11'($urandom_range(0, 2047)),
                        11'd1, 11'd2046, 11'($urandom_range(0, 2047))};
        phase_calm  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
        for (p = 0; p < 7; p++) begin
            write_limit(phase_limit[p]);
            no_gaps = phase_calm[p];
            fill_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("[remote_frame_decoder] OK");
        else
            $display("[remote_frame_decoder] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
sv/rfd_pkg.sv
sv/rfd_in_if.sv
sv/rfd_out_if.sv
sv/rfd_frame_store.sv
sv/rfd_decode.sv
sv/rfd_out_buf.sv
sv/remote_frame_decoder.sv
verif/tb_top.sv
